/* src/wdsc_pkg.sv */
// Shared widths, register indexes, reset values and stage types for the
// wall distance steering controller. No dependencies.
package wdsc_pkg;

   // Field widths.
   localparam int DIST_W     = 11;
   localparam int GAIN_W     = 12;
   localparam int STEP_W     = 8;
   localparam int LIMIT_W    = 6;
   localparam int ANGLE_W    = 8;
   localparam int SENSOR_W   = 2;
   localparam int SETPOINT_W = 15;
   localparam int FRAC_BITS  = 12;
   localparam int ERR_W      = 16;
   localparam int CORR_W     = 28;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Default depth of each averaging ring.
   localparam int AVG_DEPTH_DEF = 5;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_DIST    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_LIMIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_CENTER = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SENSOR = 3'd7;

   // Sensor codes.
   localparam logic [SENSOR_W-1:0] SENSOR_NONE   = 2'd0;
   localparam logic [SENSOR_W-1:0] SENSOR_FIRST  = 2'd1;
   localparam logic [SENSOR_W-1:0] SENSOR_SECOND = 2'd2;
   localparam logic [SENSOR_W-1:0] SENSOR_BAD    = 2'd3;

   // Limits and reset values.
   localparam logic [LIMIT_W-1:0]    MAX_LEFT       = 6'd55;
   localparam logic [LIMIT_W-1:0]    MAX_RIGHT      = 6'd45;
   localparam logic [ANGLE_W:0]      SERVO_MAX      = 9'd180;
   localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 15'd800;
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = 12'd256;
   localparam logic [DIST_W-1:0]     TARGET_RESET   = 11'd50;
   localparam logic [STEP_W-1:0]     STEP_RESET     = 8'd16;
   localparam logic [ANGLE_W-1:0]    CENTER_RESET   = 8'd80;

   // Static configuration seen by the datapath stages.
   typedef struct packed {
      logic [GAIN_W-1:0]  gain;
      logic [LIMIT_W-1:0] left_limit;
      logic [LIMIT_W-1:0] right_limit;
      logic [ANGLE_W-1:0] servo_center;
   } cfg_type;

   // Per-word control that travels down the pipeline with the data.
   typedef struct packed {
      logic                  upd;
      logic                  second;
      logic [SENSOR_W-1:0]   sensor;
      logic                  edge_found;
      logic [SETPOINT_W-1:0] setpoint;
   } tag_type;

endpackage

/* src/wdsc_ctrl.sv */
// Front stage: configuration registers, setpoint ramp, sensor selection,
// edge detection and ring slot pointers. Depends on wdsc_pkg.
module wdsc_ctrl #(
   parameter int AVG_DEPTH = wdsc_pkg::AVG_DEPTH_DEF,
   parameter int SLOT_W    = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [wdsc_pkg::DIST_W-1:0]         dist_first,
   input  logic [wdsc_pkg::DIST_W-1:0]         dist_second,
   input  logic                                csr_valid,
   input  logic [wdsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wdsc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output wdsc_pkg::cfg_type                   cfg,
   output logic                                s1_valid,
   input  logic                                s1_ready,
   output wdsc_pkg::tag_type                   s1_tag,
   output logic [SLOT_W:0]                     s1_addr,
   output logic signed [wdsc_pkg::ERR_W-1:0]   s1_err
);
   import wdsc_pkg::*;

   logic [GAIN_W-1:0]     gain_ff;
   logic [DIST_W-1:0]     target_ff;
   logic [STEP_W-1:0]     ramp_ff;
   logic [DIST_W-1:0]     edge_dist_ff;
   logic [LIMIT_W-1:0]    left_ff;
   logic [LIMIT_W-1:0]    right_ff;
   logic [ANGLE_W-1:0]    center_ff;

   logic [SENSOR_W-1:0]   sensor_ff, sensor_in;
   logic                  corner_ff, corner_in;
   logic                  armed_ff, armed_in;
   logic [SETPOINT_W-1:0] setpoint_ff, setpoint_in;
   logic [SLOT_W-1:0]     slot_first_ff, slot_first_in;
   logic [SLOT_W-1:0]     slot_second_ff, slot_second_in;

   logic                  s1_valid_ff;
   tag_type               tag_ff, tag_in;
   logic [SLOT_W:0]       addr_ff, addr_in;
   logic signed [ERR_W-1:0] err_ff, err_in;

   logic                  accept;
   logic                  active, second, upd;
   logic [DIST_W-1:0]     own_dist, other;
   logic [SETPOINT_W-1:0] tgt16, ramp_val;
   logic [SETPOINT_W+1:0] two_d, two_t, step_w;
   logic [SETPOINT_W:0]   down_v, up_v;
   logic signed [ERR_W:0] err_full;
   logic [SLOT_W-1:0]     slot_cur, slot_next;
   logic [CSR_DATA_W-1:0] wd;

   assign req_ready = !s1_valid_ff || s1_ready;
   assign accept    = req_valid && req_ready;
   assign wd        = csr_wdata;

   // Sensor selection.
   assign active   = (sensor_ff == SENSOR_FIRST) || (sensor_ff == SENSOR_SECOND);
   assign second   = (sensor_ff == SENSOR_SECOND);
   assign own_dist = second ? dist_second : dist_first;
   assign other    = second ? dist_first : dist_second;
   assign upd      = active && (own_dist != '0);

   // Setpoint ramp toward the commanded distance, compared at double scale.
   assign tgt16  = {target_ff, 4'b0000};
   assign two_d  = {1'b0, setpoint_ff, 1'b0};
   assign two_t  = {1'b0, tgt16, 1'b0};
   assign step_w = (SETPOINT_W+2)'(ramp_ff);
   assign down_v = {1'b0, setpoint_ff} - (SETPOINT_W+1)'(ramp_ff);
   assign up_v   = {1'b0, setpoint_ff} + (SETPOINT_W+1)'(ramp_ff);

   always_comb begin
      if (two_d > two_t + step_w) begin
         ramp_val = down_v[SETPOINT_W] ? '0 : down_v[SETPOINT_W-1:0];
      end else if (two_d + step_w < two_t) begin
         ramp_val = up_v[SETPOINT_W] ? '1 : up_v[SETPOINT_W-1:0];
      end else begin
         ramp_val = tgt16;
      end
   end

   assign setpoint_in = (active && (target_ff != '0)) ? ramp_val : setpoint_ff;

   // Error against the new setpoint; the range fits ERR_W signed bits.
   assign err_full = $signed({2'b00, setpoint_in}) - $signed({2'b00, own_dist, 4'b0000});
   assign err_in   = err_full[ERR_W-1:0];

   // Ring slot of the active sensor and its successor.
   assign slot_cur  = second ? slot_second_ff : slot_first_ff;
   assign slot_next = (slot_cur == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
   assign addr_in   = {second, slot_cur};

   always_comb begin
      slot_first_in  = slot_first_ff;
      slot_second_in = slot_second_ff;
      if (upd) begin
         if (second) begin
            slot_second_in = slot_next;
         end else begin
            slot_first_in = slot_next;
         end
      end
   end

   // One-time edge detection, possibly handing over to the other sensor.
   always_comb begin
      sensor_in = sensor_ff;
      corner_in = corner_ff;
      armed_in  = armed_ff;
      if (upd && !corner_ff && (edge_dist_ff != '0)) begin
         if (own_dist > edge_dist_ff) begin
            corner_in = 1'b1;
         end
         if (armed_ff) begin
            if (other > edge_dist_ff) begin
               corner_in = 1'b1;
               sensor_in = second ? SENSOR_FIRST : SENSOR_SECOND;
            end
         end else begin
            armed_in = 1'b1;
         end
      end
   end

   always_comb begin
      tag_in.upd        = upd;
      tag_in.second     = second;
      tag_in.sensor     = sensor_in;
      tag_in.edge_found = corner_in;
      tag_in.setpoint   = setpoint_in;
   end

   // Configuration and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= GAIN_RESET;
         target_ff      <= TARGET_RESET;
         ramp_ff        <= STEP_RESET;
         edge_dist_ff   <= '0;
         left_ff        <= MAX_LEFT;
         right_ff       <= MAX_RIGHT;
         center_ff      <= CENTER_RESET;
         sensor_ff      <= SENSOR_NONE;
         corner_ff      <= 1'b0;
         armed_ff       <= 1'b0;
         setpoint_ff    <= SETPOINT_RESET;
         slot_first_ff  <= '0;
         slot_second_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            sensor_ff      <= sensor_in;
            corner_ff      <= corner_in;
            armed_ff       <= armed_in;
            setpoint_ff    <= setpoint_in;
            slot_first_ff  <= slot_first_in;
            slot_second_ff <= slot_second_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_GAIN:         gain_ff      <= wd[GAIN_W-1:0];
               CSR_TARGET:       target_ff    <= wd[DIST_W-1:0];
               CSR_RAMP_STEP:    ramp_ff      <= wd[STEP_W-1:0];
               CSR_EDGE_DIST:    edge_dist_ff <= wd[DIST_W-1:0];
               CSR_LEFT_LIMIT:   left_ff  <= (wd[LIMIT_W-1:0] > MAX_LEFT) ?
                                             MAX_LEFT : wd[LIMIT_W-1:0];
               CSR_RIGHT_LIMIT:  right_ff <= (wd[LIMIT_W-1:0] > MAX_RIGHT) ?
                                             MAX_RIGHT : wd[LIMIT_W-1:0];
               CSR_SERVO_CENTER: center_ff    <= wd[ANGLE_W-1:0];
               CSR_START_SENSOR: sensor_ff <= (wd[SENSOR_W-1:0] == SENSOR_BAD) ?
                                              SENSOR_SECOND : wd[SENSOR_W-1:0];
            endcase
         end
      end
   end

   // Word register toward the ring stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff  <= tag_in;
         addr_ff <= addr_in;
         err_ff  <= err_in;
      end
   end

   assign cfg.gain         = gain_ff;
   assign cfg.left_limit   = left_ff;
   assign cfg.right_limit  = right_ff;
   assign cfg.servo_center = center_ff;

   assign s1_valid = s1_valid_ff;
   assign s1_tag   = tag_ff;
   assign s1_addr  = addr_ff;
   assign s1_err   = err_ff;

endmodule

/* src/wdsc_ring.sv */
// Gain multiply and the averaging rings: one synchronous memory holds both
// rings, read-modify-written with running sums. Depends on wdsc_pkg.
module wdsc_ring #(
   parameter int AVG_DEPTH = wdsc_pkg::AVG_DEPTH_DEF,
   parameter int SLOT_W    = 3,
   parameter int SUM_W     = 31
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [wdsc_pkg::GAIN_W-1:0]        gain,
   input  logic                               s1_valid,
   output logic                               s1_ready,
   input  wdsc_pkg::tag_type                  s1_tag,
   input  logic [SLOT_W:0]                    s1_addr,
   input  logic signed [wdsc_pkg::ERR_W-1:0]  s1_err,
   output logic                               s3_valid,
   input  logic                               s3_ready,
   output wdsc_pkg::tag_type                  s3_tag,
   output logic signed [SUM_W-1:0]            s3_sum
);
   import wdsc_pkg::*;

   localparam int ENTRIES = 2 ** (SLOT_W + 1);
   localparam int PROD_W  = ERR_W + GAIN_W + 1;

   logic [CORR_W-1:0]        ring_mem [ENTRIES];
   logic [ENTRIES-1:0]       ring_vld_ff;
   logic [CORR_W-1:0]        rd_data_ff;
   logic                     rd_vld_ff;

   logic                     s2_valid_ff;
   tag_type                  s2_tag_ff;
   logic [SLOT_W:0]          s2_addr_ff;
   logic signed [CORR_W-1:0] s2_corr_ff;

   logic                     s3_valid_ff;
   tag_type                  s3_tag_ff;
   logic signed [SUM_W-1:0]  s3_sum_ff;

   logic signed [SUM_W-1:0]  sum_first_ff, sum_second_ff;
   logic signed [SUM_W-1:0]  sum_sel, sum_in;
   logic signed [CORR_W-1:0] old_data;
   logic signed [PROD_W-1:0] prod;
   logic                     s2_ready, wr_en, fwd;

   assign s2_ready = !s3_valid_ff || s3_ready;
   assign s1_ready = !s2_valid_ff || s2_ready;

   // Correction: error times the Q4.8 gain.
   assign prod = s1_err * $signed({1'b0, gain});

   // Ring write happens when an updating word leaves the sum stage.
   assign wr_en = s2_valid_ff && s2_ready && s2_tag_ff.upd;
   assign fwd   = wr_en && (s2_addr_ff == s1_addr);

   // Oldest entry leaves the running sum, the new correction enters.
   assign old_data = rd_vld_ff ? $signed(rd_data_ff) : '0;
   assign sum_sel  = s2_tag_ff.second ? sum_second_ff : sum_first_ff;
   assign sum_in   = sum_sel - SUM_W'(old_data) + SUM_W'(s2_corr_ff);

   // Ring memory, with the word written this edge forwarded to the reader.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[s2_addr_ff] <= s2_corr_ff;
      end
      if (s1_ready) begin
         rd_data_ff <= fwd ? s2_corr_ff : ring_mem[s1_addr];
      end
   end

   // Entry valid bits make unwritten entries read as zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         sum_first_ff  <= '0;
         sum_second_ff <= '0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            ring_vld_ff[s2_addr_ff] <= 1'b1;
            if (s2_tag_ff.second) begin
               sum_second_ff <= sum_in;
            end else begin
               sum_first_ff <= sum_in;
            end
         end
         if (s1_ready) begin
            rd_vld_ff   <= fwd || ring_vld_ff[s1_addr];
            s2_valid_ff <= s1_valid;
         end
         if (s2_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Word registers of the multiply and sum stages.
   always_ff @(posedge clock) begin
      if (s1_valid && s1_ready) begin
         s2_tag_ff  <= s1_tag;
         s2_addr_ff <= s1_addr;
         s2_corr_ff <= prod[CORR_W-1:0];
      end
      if (s2_valid_ff && s2_ready) begin
         s3_tag_ff <= s2_tag_ff;
         s3_sum_ff <= sum_in;
      end
   end

   assign s3_valid = s3_valid_ff;
   assign s3_tag   = s3_tag_ff;
   assign s3_sum   = s3_sum_ff;

endmodule

/* src/wdsc_angle.sv */
// Average, clamp and servo angle: clamps the ring sum, divides it by the
// ring depth through a reciprocal multiply and forms the result word.
// Depends on wdsc_pkg.
module wdsc_angle #(
   parameter int AVG_DEPTH = wdsc_pkg::AVG_DEPTH_DEF,
   parameter int SLOT_W    = 3,
   parameter int SUM_W     = 31
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wdsc_pkg::cfg_type                    cfg,
   input  logic                                 s3_valid,
   output logic                                 s3_ready,
   input  wdsc_pkg::tag_type                    s3_tag,
   input  logic signed [SUM_W-1:0]              s3_sum,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wdsc_pkg::ANGLE_W-1:0]         rsp_servo_angle,
   output logic                                 rsp_servo_update,
   output logic [wdsc_pkg::SENSOR_W-1:0]        rsp_sensor_in_use,
   output logic                                 rsp_edge_found,
   output logic [wdsc_pkg::SETPOINT_W-1:0]      rsp_setpoint
);
   import wdsc_pkg::*;

   // Clamped sums stay at most limit * 2^FRAC_BITS * depth + depth - 1, within MAG_W bits.
   localparam int MAG_W   = LIMIT_W + FRAC_BITS + SLOT_W;
   localparam int SHIFT_K = MAG_W + SLOT_W;
   localparam int Q_W     = LIMIT_W + FRAC_BITS;
   localparam int PROD_W  = MAG_W + SHIFT_K + 1;
   localparam logic [SHIFT_K:0] RECIP =
      (SHIFT_K+1)'(((64'd1 << SHIFT_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
   localparam int VAL_W   = ANGLE_W + FRAC_BITS + 2;

   logic                    s4_valid_ff, s5_valid_ff, out_valid_ff;
   tag_type                 s4_tag_ff, s5_tag_ff;
   logic                    s4_neg_ff, s5_neg_ff;
   logic [MAG_W-1:0]        s4_mag_ff;
   logic [Q_W-1:0]          s5_q_ff;
   logic                    s4_ready, s5_ready;

   logic [ANGLE_W-1:0]      angle_ff;
   logic                    update_ff;
   logic [SENSOR_W-1:0]     sensor_ff;
   logic                    edge_found_ff;
   logic [SETPOINT_W-1:0]   setpoint_ff;

   logic [LIMIT_W-1:0]      hi_lim, lo_lim;
   logic [MAG_W-1:0]        hi_bound, lo_bound;
   logic signed [SUM_W-1:0] hi_s, lo_s, abs_sum;
   logic                    neg_in;
   logic [MAG_W-1:0]        mag_in;
   logic [PROD_W-1:0]       prod;
   logic signed [VAL_W-1:0] center_s, q_s, val;
   logic [VAL_W-FRAC_BITS-2:0] whole;
   logic [ANGLE_W-1:0]      deg;

   assign s5_ready = !out_valid_ff || rsp_ready;
   assign s4_ready = !s5_valid_ff || s5_ready;
   assign s3_ready = !s4_valid_ff || s4_ready;

   // Clamp bounds on the sum: limit * 2^FRAC_BITS * depth plus depth - 1,
   // so that the truncated quotient lands exactly on the limit.
   assign hi_lim   = s3_tag.second ? cfg.left_limit : cfg.right_limit;
   assign lo_lim   = s3_tag.second ? cfg.right_limit : cfg.left_limit;
   assign hi_bound = MAG_W'({hi_lim, {FRAC_BITS{1'b0}}}) * MAG_W'(AVG_DEPTH)
                     + MAG_W'(AVG_DEPTH - 1);
   assign lo_bound = MAG_W'({lo_lim, {FRAC_BITS{1'b0}}}) * MAG_W'(AVG_DEPTH)
                     + MAG_W'(AVG_DEPTH - 1);
   assign hi_s     = $signed(SUM_W'(hi_bound));
   assign lo_s     = $signed(SUM_W'(lo_bound));
   assign abs_sum  = s3_sum[SUM_W-1] ? -s3_sum : s3_sum;

   always_comb begin
      if (s3_sum > hi_s) begin
         neg_in = 1'b0;
         mag_in = hi_bound;
      end else if (s3_sum < -lo_s) begin
         neg_in = 1'b1;
         mag_in = lo_bound;
      end else begin
         neg_in = s3_sum[SUM_W-1];
         mag_in = abs_sum[MAG_W-1:0];
      end
   end

   // Division by the ring depth as a reciprocal multiply.
   assign prod = PROD_W'(s4_mag_ff) * PROD_W'(RECIP);

   // Servo angle: center moved by the signed average, truncated, saturated.
   assign center_s = $signed(VAL_W'({cfg.servo_center, {FRAC_BITS{1'b0}}}));
   assign q_s      = $signed(VAL_W'(s5_q_ff));
   assign val      = ((!s5_tag_ff.second) ^ s5_neg_ff) ? center_s - q_s : center_s + q_s;
   assign whole    = val[VAL_W-2:FRAC_BITS];

   always_comb begin
      if (val[VAL_W-1]) begin
         deg = '0;
      end else if (whole > (VAL_W-FRAC_BITS-1)'(SERVO_MAX)) begin
         deg = SERVO_MAX[ANGLE_W-1:0];
      end else begin
         deg = whole[ANGLE_W-1:0];
      end
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s4_valid_ff <= s3_valid;
         end
         if (s4_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (s5_ready) begin
            out_valid_ff <= s5_valid_ff;
         end
      end
   end

   // Stage words and the output register.
   always_ff @(posedge clock) begin
      if (s3_valid && s3_ready) begin
         s4_tag_ff <= s3_tag;
         s4_neg_ff <= neg_in;
         s4_mag_ff <= mag_in;
      end
      if (s4_valid_ff && s4_ready) begin
         s5_tag_ff <= s4_tag_ff;
         s5_neg_ff <= s4_neg_ff;
         s5_q_ff   <= prod[SHIFT_K +: Q_W];
      end
      if (s5_valid_ff && s5_ready) begin
         angle_ff      <= s5_tag_ff.upd ? deg : '0;
         update_ff     <= s5_tag_ff.upd;
         sensor_ff     <= s5_tag_ff.sensor;
         edge_found_ff <= s5_tag_ff.edge_found;
         setpoint_ff   <= s5_tag_ff.setpoint;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_servo_angle   = angle_ff;
   assign rsp_servo_update  = update_ff;
   assign rsp_sensor_in_use = sensor_ff;
   assign rsp_edge_found    = edge_found_ff;
   assign rsp_setpoint      = setpoint_ff;

endmodule

/* src/wall_distance_steering_controller.sv */
// Top level of the wall distance steering controller.
// Depends on wdsc_pkg, wdsc_ctrl, wdsc_ring and wdsc_angle.
//
//   Channel  Ports                              Word
//   req      req_valid / req_ready              dist_first, dist_second
//   rsp      rsp_valid / rsp_ready              servo_angle, servo_update,
//                                               sensor_in_use, edge_found, setpoint
//   csr      csr_valid / csr_ready (always 1)   csr_index, csr_wdata
//
// One word is accepted per cycle unless backpressure holds the pipeline; each
// result passes the ramp, multiply, ring update, clamp, divide and output stages.
// Without stalls the rate is one word per cycle, set by the single read and write
// port of the ring memory, which each word touches once.
// Synchronous reset clears the ring valid bits and running sums at once;
// no clearing pass is needed. Every stage holds under backpressure and takes
// a new word whenever the stage after it is empty or moving.
module wall_distance_steering_controller #(
   parameter int AVG_DEPTH = wdsc_pkg::AVG_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wdsc_pkg::DIST_W-1:0]       req_dist_first,
   input  logic [wdsc_pkg::DIST_W-1:0]       req_dist_second,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wdsc_pkg::ANGLE_W-1:0]      rsp_servo_angle,
   output logic                              rsp_servo_update,
   output logic [wdsc_pkg::SENSOR_W-1:0]     rsp_sensor_in_use,
   output logic                              rsp_edge_found,
   output logic [wdsc_pkg::SETPOINT_W-1:0]   rsp_setpoint,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wdsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wdsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wdsc_pkg::*;

   localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W  = CORR_W + SLOT_W;

   cfg_type                 cfg;
   logic                    s1_valid, s1_ready;
   tag_type                 s1_tag;
   logic [SLOT_W:0]         s1_addr;
   logic signed [ERR_W-1:0] s1_err;
   logic                    s3_valid, s3_ready;
   tag_type                 s3_tag;
   logic signed [SUM_W-1:0] s3_sum;

   // Register writes never stall.
   assign csr_ready = 1'b1;

   wdsc_ctrl #(
      .AVG_DEPTH (AVG_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .dist_first  (req_dist_first),
      .dist_second (req_dist_second),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .s1_valid    (s1_valid),
      .s1_ready    (s1_ready),
      .s1_tag      (s1_tag),
      .s1_addr     (s1_addr),
      .s1_err      (s1_err)
   );

   wdsc_ring #(
      .AVG_DEPTH (AVG_DEPTH),
      .SLOT_W    (SLOT_W),
      .SUM_W     (SUM_W)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .gain     (cfg.gain),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_tag   (s1_tag),
      .s1_addr  (s1_addr),
      .s1_err   (s1_err),
      .s3_valid (s3_valid),
      .s3_ready (s3_ready),
      .s3_tag   (s3_tag),
      .s3_sum   (s3_sum)
   );

   wdsc_angle #(
      .AVG_DEPTH (AVG_DEPTH),
      .SLOT_W    (SLOT_W),
      .SUM_W     (SUM_W)
   ) u_angle (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .s3_valid          (s3_valid),
      .s3_ready          (s3_ready),
      .s3_tag            (s3_tag),
      .s3_sum            (s3_sum),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_servo_angle   (rsp_servo_angle),
      .rsp_servo_update  (rsp_servo_update),
      .rsp_sensor_in_use (rsp_sensor_in_use),
      .rsp_edge_found    (rsp_edge_found),
      .rsp_setpoint      (rsp_setpoint)
   );

endmodule
